@@ hdl/ipt_pkg.sv @@
// shared types, constants and codes for the inverted page table
`timescale 1ns / 1ps
`default_nettype none
package ipt_pkg;

	localparam int ADDR_W         = 48;
	localparam int NUM_FRAMES_DEF = 64;
	localparam int TIME_W         = 64;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY        = 2'd2;

	// replacement policy codes
	localparam logic [1:0] POL_FIFO  = 2'd0;
	localparam logic [1:0] POL_LRU   = 2'd1;
	localparam logic [1:0] POL_CLOCK = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] logical_address;
		logic              write_access;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] physical_address;
		logic              page_fault;
		logic              swap_in;
		logic              swap_out;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic match;
		logic sel_hit;
		logic sel_free;
		logic sel_fifo;
		logic lru_start;
		logic lru_step;
		logic clk_start;
		logic clk_step;
		logic commit;
	} ipt_cmd_t;

	typedef struct packed {
		logic       hit;
		logic       have_free;
		logic       lru_done;
		logic       clk_done;
		logic [1:0] policy;
	} ipt_sts_t;

endpackage
`default_nettype wire

@@ hdl/ipt_dp.sv @@
// datapath: frame table, lookup, victim search and result register
`timescale 1ns / 1ps
`default_nettype none
module ipt_dp #(
	parameter int NUM_FRAMES = ipt_pkg::NUM_FRAMES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [ipt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [ipt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  ipt_pkg::in_item_t                in_data,
	input  ipt_pkg::ipt_cmd_t                cmd,
	output ipt_pkg::ipt_sts_t                sts,
	output ipt_pkg::out_item_t               out_data
);
	import ipt_pkg::*;

	localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = ($clog2(NUM_FRAMES + 1) > 7) ? $clog2(NUM_FRAMES + 1) : 7;

	logic [4:0]              offset_bits_q;
	logic [6:0]              frames_in_use_q;
	logic [1:0]              policy_q;
	logic [CW-1:0]           frames_ext;
	logic [CW-1:0]           n_cnt;
	logic [NUM_FRAMES-1:0]   in_range;

	logic [ADDR_W-1:0]       page_q;
	logic [ADDR_W-1:0]       off_q;
	logic                    wr_q;

	logic [ADDR_W-1:0]       resident_q [NUM_FRAMES];
	logic [NUM_FRAMES-1:0]   free_q;
	logic [NUM_FRAMES-1:0]   dirty_q;
	logic [NUM_FRAMES-1:0]   use_q;
	logic [TIME_W-1:0]       time_mem [NUM_FRAMES];
	logic [TIME_W-1:0]       access_clock_q;

	logic [NUM_FRAMES-1:0]   match_s1;
	logic [NUM_FRAMES-1:0]   free_s1;
	logic [IW-1:0]           hit_idx;
	logic [IW-1:0]           free_idx;

	logic [IW-1:0]           frame_q;
	logic                    hit_q;
	logic                    victim_q;
	logic [IW-1:0]           fifo_ptr_q;
	logic [IW-1:0]           clock_ptr_q;
	logic [IW-1:0]           fifo_v;
	logic [IW-1:0]           fifo_next;
	logic [IW-1:0]           clock_start;
	logic [IW-1:0]           hand_q;
	logic [IW-1:0]           hand_next;
	logic                    clk_done;

	logic [CW-1:0]           rd_ptr_q;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           data_idx_q;
	logic [TIME_W-1:0]       time_rd_q;
	logic [TIME_W-1:0]       best_time_q;
	logic [IW-1:0]           best_idx_q;
	logic                    best_valid_q;
	logic                    lru_last;
	logic                    lru_take;
	logic [IW-1:0]           lru_win;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q   <= 5'd12;
			frames_in_use_q <= 7'd64;
			policy_q        <= POL_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OFFSET_BITS:   offset_bits_q   <= cfg_data[4:0];
				CFG_FRAMES_IN_USE: frames_in_use_q <= cfg_data[6:0];
				CFG_POLICY:        policy_q        <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// managed frame count, clamped to one..table depth
	assign frames_ext = CW'(frames_in_use_q);
	always_comb begin
		if (frames_ext == '0)
			n_cnt = CW'(1);
		else if (frames_ext > CW'(NUM_FRAMES))
			n_cnt = CW'(NUM_FRAMES);
		else
			n_cnt = frames_ext;
	end

	always_comb begin
		for (int i = 0; i < NUM_FRAMES; i++)
			in_range[i] = CW'(i) < n_cnt;
	end

	// split of the accepted address into page and offset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= in_data.logical_address >> offset_bits_q;
			off_q  <= in_data.logical_address & ~({ADDR_W{1'b1}} << offset_bits_q);
			wr_q   <= in_data.write_access;
		end
	end

	// parallel tag compare, registered
	always_ff @(posedge clk) begin
		if (cmd.match) begin
			for (int i = 0; i < NUM_FRAMES; i++) begin
				match_s1[i] <= !free_q[i] && in_range[i] && (resident_q[i] == page_q);
				free_s1[i]  <= free_q[i] && in_range[i];
			end
		end
	end

	// lowest set index of the hit and free vectors
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (match_s1[i])
				hit_idx = IW'(i);
			if (free_s1[i])
				free_idx = IW'(i);
		end
	end

	// fifo and clock pointer arithmetic
	assign fifo_v      = (CW'(fifo_ptr_q) < n_cnt) ? fifo_ptr_q : '0;
	assign fifo_next   = (CW'(fifo_v) + CW'(1) == n_cnt) ? '0 : fifo_v + IW'(1);
	assign clock_start = (CW'(clock_ptr_q) < n_cnt) ? clock_ptr_q : '0;
	assign hand_next   = (CW'(hand_q) + CW'(1) == n_cnt) ? '0 : hand_q + IW'(1);
	assign clk_done    = !use_q[hand_q];

	// lru scan compare
	assign lru_last = (CW'(data_idx_q) == n_cnt - CW'(1));
	assign lru_take = !best_valid_q || (time_rd_q < best_time_q);
	assign lru_win  = lru_take ? data_idx_q : best_idx_q;
	assign rd_addr  = cmd.lru_start ? '0 : rd_ptr_q[IW-1:0];

	// access time memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit)
			time_mem[frame_q] <= access_clock_q + TIME_W'(1);
		time_rd_q <= time_mem[rd_addr];
	end

	// lru scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q     <= '0;
			data_idx_q   <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.lru_start) begin
			rd_ptr_q     <= CW'(1);
			data_idx_q   <= '0;
			best_valid_q <= 1'b0;
		end else if (cmd.lru_step) begin
			best_valid_q <= 1'b1;
			if (!lru_last) begin
				rd_ptr_q   <= rd_ptr_q + CW'(1);
				data_idx_q <= rd_ptr_q[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lru_step && lru_take) begin
			best_time_q <= time_rd_q;
			best_idx_q  <= data_idx_q;
		end
	end

	// frame choice and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q         <= '1;
			dirty_q        <= '0;
			use_q          <= '0;
			access_clock_q <= '0;
			fifo_ptr_q     <= '0;
			clock_ptr_q    <= '0;
			hand_q         <= '0;
			frame_q        <= '0;
			hit_q          <= 1'b0;
			victim_q       <= 1'b0;
		end else begin
			if (cmd.sel_hit) begin
				frame_q  <= hit_idx;
				hit_q    <= 1'b1;
				victim_q <= 1'b0;
			end
			if (cmd.sel_free) begin
				frame_q  <= free_idx;
				hit_q    <= 1'b0;
				victim_q <= 1'b0;
			end
			if (cmd.sel_fifo) begin
				frame_q    <= fifo_v;
				fifo_ptr_q <= fifo_next;
				hit_q      <= 1'b0;
				victim_q   <= 1'b1;
			end
			if (cmd.lru_start) begin
				hit_q    <= 1'b0;
				victim_q <= 1'b1;
			end
			if (cmd.lru_step && lru_last)
				frame_q <= lru_win;
			if (cmd.clk_start) begin
				hand_q   <= clock_start;
				hit_q    <= 1'b0;
				victim_q <= 1'b1;
			end
			// second chance: clear and move on, or take the frame
			if (cmd.clk_step) begin
				if (clk_done) begin
					frame_q     <= hand_q;
					clock_ptr_q <= hand_next;
				end else begin
					use_q[hand_q] <= 1'b0;
					hand_q        <= hand_next;
				end
			end
			if (cmd.commit) begin
				access_clock_q <= access_clock_q + TIME_W'(1);
				use_q[frame_q] <= 1'b1;
				if (hit_q) begin
					if (wr_q)
						dirty_q[frame_q] <= 1'b1;
				end else begin
					free_q[frame_q]  <= 1'b0;
					dirty_q[frame_q] <= wr_q;
				end
			end
		end
	end

	// page store and result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (!hit_q)
				resident_q[frame_q] <= page_q;
			out_data.physical_address <= (ADDR_W'(frame_q) << offset_bits_q) | off_q;
			out_data.page_fault       <= !hit_q;
			out_data.swap_in          <= !hit_q;
			out_data.swap_out         <= victim_q && dirty_q[frame_q];
		end
	end

	// status towards the controller
	assign sts.hit       = |match_s1;
	assign sts.have_free = |free_s1;
	assign sts.lru_done  = lru_last;
	assign sts.clk_done  = clk_done;
	assign sts.policy    = policy_q;

endmodule
`default_nettype wire

@@ hdl/ipt_ctrl.sv @@
// controller: access sequencing and handshakes
`timescale 1ns / 1ps
`default_nettype none
module ipt_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  ipt_pkg::ipt_sts_t  sts,
	output ipt_pkg::ipt_cmd_t  cmd
);
	import ipt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MATCH  = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_LRU    = 3'd3;
	localparam logic [2:0] S_CLK    = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MATCH;
				end
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.hit) begin
					cmd.sel_hit = 1'b1;
					state_d     = S_DONE;
				end else if (sts.have_free) begin
					cmd.sel_free = 1'b1;
					state_d      = S_DONE;
				end else begin
					case (sts.policy)
						POL_LRU: begin
							cmd.lru_start = 1'b1;
							state_d       = S_LRU;
						end
						POL_CLOCK: begin
							cmd.clk_start = 1'b1;
							state_d       = S_CLK;
						end
						default: begin
							cmd.sel_fifo = 1'b1;
							state_d      = S_DONE;
						end
					endcase
				end
			end
			S_LRU: begin
				cmd.lru_step = 1'b1;
				if (sts.lru_done)
					state_d = S_DONE;
			end
			S_CLK: begin
				cmd.clk_step = 1'b1;
				if (sts.clk_done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ hdl/inverted_page_table_with_replacement.sv @@
// top level: inverted page table with fifo, lru and clock replacement
// a hit or a free-frame fill passes the match, decide and done states; the result is registered on commit
// lru miss: a scan state reads one access time per managed frame from the time memory
// clock miss: one use bit examined per cycle by the hand until it finds one clear
// the next access is taken only after the last one commits; a waiting result holds its commit until read
// reset: asynchronous, marks every frame free, clears dirty and use flags, counters and pointers at once
`timescale 1ns / 1ps
`default_nettype none
module inverted_page_table_with_replacement #(
	parameter int NUM_FRAMES = ipt_pkg::NUM_FRAMES_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire  [ipt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [ipt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  ipt_pkg::in_item_t               in_data,
	output logic                            out_valid,
	input  wire                             out_ready,
	output ipt_pkg::out_item_t              out_data
);
	import ipt_pkg::*;

	ipt_cmd_t cmd;
	ipt_sts_t sts;

	// sequencing
	ipt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table and search
	ipt_dp #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

`ifndef NO_ASSERTIONS
	// one access in flight: no transfer in right after one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an access is in flight");

	// a write-back only comes with a fault
	a_swap_out_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.swap_out |-> out_data.page_fault)
		else $error("swap out without page fault");

	// swap in mirrors the fault flag
	a_swap_in_fault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.swap_in == out_data.page_fault)
		else $error("swap in differs from page fault");

	// no result is committed in the match or decide state after an access is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !cmd.commit ##1 !cmd.commit)
		else $error("result committed too early");
`endif

endmodule
`default_nettype wire
